// ----- rtl/emg_pkg.sv -----
package emg_pkg;

    localparam int Window     = 1024;
    localparam int WinBits    = $clog2(Window);
    localparam int WinShift   = $clog2(Window);
    localparam int CalibCount = 4096;
    localparam int CalShift   = $clog2(CalibCount);
    localparam int CntBits    = $clog2(CalibCount + 1);

    localparam logic [25:0] VoltScale = 26'd55364813;
    localparam logic signed [18:0] NqA0 = 19'sd65464;
    localparam logic signed [18:0] NqA1 = -19'sd130135;
    localparam logic signed [18:0] NqA2 = 19'sd65464;
    localparam logic signed [18:0] NqB1 = 19'sd130115;
    localparam logic signed [18:0] NqB2 = -19'sd65372;
    localparam logic [23:0] RestReset     = 24'd117441;
    localparam logic [23:0] ContractReset = 24'd2516582;

    localparam logic [1:0] CfgNotch = 2'd0;
    localparam logic [1:0] CfgLpA   = 2'd1;
    localparam logic [1:0] CfgHpA   = 2'd2;
    localparam logic [1:0] CfgEnvA  = 2'd3;

    localparam logic [1:0] ActNone     = 2'd0;
    localparam logic [1:0] ActRest     = 2'd1;
    localparam logic [1:0] ActContract = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LP, S_HP, S_N0, S_N1, S_N2, S_N3, S_N4,
        S_NR, S_SQ, S_RING, S_SQRT, S_ENV, S_CAL, S_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Round half up of v / 2^16 (arithmetic shift is floor).
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
        logic signed [63:0] b;
        b = v + 64'sd32768;
        return b >>> 16;
    endfunction

endpackage

// ----- rtl/emg_rms_envelope_top.sv -----
// EMG moving-RMS envelope.
// Input channel s_axis: tdata holds the 12-bit ADC sample, tuser the 2-bit
// action (0 sample only, 1 start rest calibration, 2 start contract).
// Output channel m_axis: tdata carries envelope, filtered, rest_level and
// contract_level; tuser carries calib_busy and calib_done.
// One sample is worked on at a time. The result of a sample reaches the
// output register after the filter, square, ring, square root, envelope and
// calibration steps, with the notch steps skipped when it is bypassed, and
// the block takes the next sample only once that result has been stored.
// The low-pass filter and the notch taps share one multiplier over seven
// steps, the window ring is one RAM with a read-modify-write of one entry,
// and the square root is a bit-serial unit.
// While a result waits unaccepted the next sample may still be processed up
// to its output step, where it stalls and s_axis_tready stays low.
// After reset the block sweeps the 1024-entry ring to zero before it
// accepts a sample. Configuration writes through i_cfg_* are
// taken at any time and should happen only while the block is idle.
module emg_rms_envelope_top
    import emg_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // sample[11:0]
    input  logic [1:0]   s_axis_tuser,   // action[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // envelope, filtered, rest, contract
    output logic [1:0]   m_axis_tuser    // calib_busy, calib_done
);
    t_state r_state, n_state;

    logic        r_notch_en;
    logic [15:0] r_lp_a, r_hp_a, r_env_a;
    logic signed [31:0] r_lp, r_lp_prev, r_hp, r_x1, r_x2, r_y1, r_y2, r_y;
    logic signed [31:0] r_x;
    logic [1:0]  r_act;
    logic [WinBits-1:0] r_pos;
    logic [41:0] r_total;
    logic [31:0] r_sq;
    logic [23:0] r_env;
    logic [36:0] r_ctot;
    logic [CntBits-1:0] r_ccnt;
    logic [1:0]  r_cmode;
    logic [23:0] r_rest, r_contract;
    logic        r_done;
    logic signed [63:0] r_acc;
    logic [WinBits:0] r_clr;
    logic        r_ovalid;
    logic [103:0] r_odata;
    logic [1:0]  r_ouser;

    // Shared multiplier operands.
    logic signed [32:0] w_ma;
    logic signed [19:0] w_mb;
    logic signed [63:0] w_prod;
    assign w_prod = 64'(w_ma) * 64'(w_mb);

    logic        w_we;
    logic [WinBits-1:0] w_waddr;
    logic [31:0] w_wdata, w_rdata;
    logic        w_sq_start, w_sq_done;
    logic [23:0] w_root;
    logic [47:0] w_mean;
    logic [41:0] w_total_new;

    assign w_total_new = r_total + 42'(r_sq) - 42'(w_rdata);
    assign w_mean = 48'({w_total_new, 16'd0} >> WinShift);

    emg_ram #(.Width(32), .Depth(Window)) u_ring (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_pos), .o_rdata(w_rdata)
    );

    emg_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start),
        .i_value(w_mean), .o_done(w_sq_done), .o_root(w_root)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_we    = (r_state == S_CLEAR) || (r_state == S_RING);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr[WinBits-1:0] : r_pos;
    assign w_wdata = (r_state == S_CLEAR) ? 32'd0 : r_sq;
    assign w_sq_start = (r_state == S_RING);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_LP:   begin w_ma = 33'(r_x); w_mb = 20'(r_lp_a); end
            S_HP:   begin w_ma = 33'(r_lp); w_mb = 20'(17'h10000 - 17'(r_lp_a)); end
            S_N0:   begin w_ma = 33'(r_hp); w_mb = 20'(NqA0); end
            S_N1:   begin w_ma = 33'(r_x1); w_mb = 20'(NqA1); end
            S_N2:   begin w_ma = 33'(r_x2); w_mb = 20'(NqA2); end
            S_N3:   begin w_ma = 33'(r_y1); w_mb = 20'(NqB1); end
            S_N4:   begin w_ma = 33'(r_y2); w_mb = 20'(NqB2); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == (WinBits+1)'(Window - 1)) n_state = S_IDLE;
            S_IDLE:  if (s_axis_tvalid) n_state = S_LP;
            S_LP:    n_state = S_HP;
            S_HP:    n_state = S_NR;
            S_NR:    n_state = r_notch_en ? S_N0 : S_SQ;
            S_N0:    n_state = S_N1;
            S_N1:    n_state = S_N2;
            S_N2:    n_state = S_N3;
            S_N3:    n_state = S_N4;
            S_N4:    n_state = S_SQ;
            S_SQ:    n_state = S_RING;
            S_RING:  n_state = S_SQRT;
            S_SQRT:  if (w_sq_done) n_state = S_ENV;
            S_ENV:   n_state = S_CAL;
            S_CAL:   n_state = S_OUT;
            S_OUT:   if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // The square is formed from the absolute value of the filtered sample.
    logic [31:0] w_mag;
    logic [63:0] w_sqfull;
    assign w_mag    = r_y[31] ? 32'(-r_y) : 32'(r_y);
    assign w_sqfull = 64'(w_mag) * 64'(w_mag);

    logic signed [63:0] w_nacc;
    logic signed [31:0] w_ynew, w_hp_new;
    logic [63:0] w_env_full;
    logic [36:0] w_ctot;
    logic [CntBits-1:0] w_ccnt;
    logic [1:0] w_mode;
    logic [1:0] w_kind;
    logic       w_cal_done;
    logic [23:0] w_lvl;

    always_comb begin
        w_hp_new = sat32(rnd16(64'(r_hp_a) *
                   (64'(r_hp) + 64'(r_lp) - 64'(r_lp_prev))));
        w_nacc = r_acc + w_prod;
        w_ynew = sat32(rnd16(w_nacc));
        w_env_full = 64'(rnd16(64'(r_env_a) * 64'(w_root) +
                     64'(17'h10000 - 17'(r_env_a)) * 64'(r_env)));
        w_mode = r_cmode; w_ctot = r_ctot; w_ccnt = r_ccnt;
        w_kind = ActNone; w_cal_done = 1'b0; w_lvl = '0;
        if (r_cmode == ActNone &&
            (r_act == ActRest || r_act == ActContract)) begin
            w_mode = r_act; w_ctot = '0; w_ccnt = '0;
        end
        if (w_mode != ActNone) begin
            w_ctot = w_ctot + 37'(r_env);
            w_ccnt = w_ccnt + 1'b1;
            if (w_ccnt == CntBits'(CalibCount)) begin
                w_lvl = 24'((w_ctot + 37'(CalibCount / 2)) >> CalShift);
                w_kind = w_mode;
                w_mode = ActNone; w_ctot = '0; w_ccnt = '0;
                w_cal_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_notch_en <= 1'b1;
            r_lp_a <= 16'd34322;
            r_hp_a <= 16'd64126;
            r_env_a <= 16'd430;
            r_lp <= '0; r_lp_prev <= '0; r_hp <= '0;
            r_x1 <= '0; r_x2 <= '0; r_y1 <= '0; r_y2 <= '0;
            r_pos <= '0; r_total <= '0; r_env <= '0;
            r_ctot <= '0; r_ccnt <= '0; r_cmode <= ActNone;
            r_rest <= RestReset; r_contract <= ContractReset;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgNotch: r_notch_en <= i_cfg_wdata[0];
                    CfgLpA:   r_lp_a <= i_cfg_wdata;
                    CfgHpA:   r_hp_a <= i_cfg_wdata;
                    CfgEnvA:  r_env_a <= i_cfg_wdata;
                    default:  ;
                endcase
            end
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: if (s_axis_tvalid) begin
                    r_x <= 32'((64'(s_axis_tdata[11:0]) * 64'(VoltScale)
                          + 64'd2048) >> 12);
                    r_act <= s_axis_tuser;
                end
                S_LP: r_acc <= w_prod;
                S_HP: begin
                    r_lp <= sat32(rnd16(r_acc + w_prod));
                end
                S_NR: begin
                    r_hp <= w_hp_new;
                    r_lp_prev <= r_lp;
                    r_y <= w_hp_new;
                    r_acc <= '0;
                end
                S_N0, S_N1, S_N2, S_N3: r_acc <= r_acc + w_prod;
                S_N4: begin
                    r_y <= w_ynew;
                    r_x2 <= r_x1; r_x1 <= r_hp;
                    r_y2 <= r_y1; r_y1 <= w_ynew;
                end
                S_SQ: r_sq <= (w_sqfull[63:48] != 16'd0) ? 32'hffffffff
                              : w_sqfull[47:16];
                S_RING: begin
                    r_total <= w_total_new;
                    r_pos <= r_pos + 1'b1;
                end
                S_ENV: begin
                    r_env <= w_env_full[23:0];
                end
                S_CAL: begin
                    r_cmode <= w_mode; r_ctot <= w_ctot; r_ccnt <= w_ccnt;
                    r_done <= w_cal_done;
                    if (w_kind == ActRest) r_rest <= w_lvl;
                    if (w_kind == ActContract) r_contract <= w_lvl;
                end
                S_OUT: if (!r_ovalid || m_axis_tready) begin
                    r_odata <= {r_contract, r_rest, r_y, r_env};
                    r_ouser <= {r_done, r_cmode != ActNone};
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
endmodule

// ----- rtl/emg_ram.sv -----
module emg_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/emg_sqrt.sv -----
module emg_sqrt
    import emg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_value,
    output logic        o_done,
    output logic [23:0] o_root
);
    logic [47:0] r_rem;
    logic [23:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [25:0] w_trial;
    logic [49:0] r_acc;
    logic [49:0] w_shift;
    logic [49:0] w_sub;

    // Restoring digit-by-digit root, one result bit per cycle.
    assign w_trial = {r_root, 2'b01};
    assign w_shift = {r_acc[47:0], r_rem[47:46]};
    assign w_sub   = w_shift - {24'd0, w_trial};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= i_value;
                r_root <= 24'd0;
                r_acc  <= 50'd0;
            end else if (r_busy) begin
                r_rem <= {r_rem[45:0], 2'b00};
                if (!w_sub[49]) begin
                    r_acc  <= w_sub;
                    r_root <= {r_root[22:0], 1'b1};
                end else begin
                    r_acc  <= w_shift;
                    r_root <= {r_root[22:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
